### design/sse_pkg.sv
`timescale 1ns / 1ps

package sse_pkg;

  // Default store depth in bytes
  localparam int RES_BYTES_DEF = 65536;

  // Width of offset arithmetic: 32-bit offsets plus header span and carry
  localparam int OFS_W = 34;

  // Resource layout
  localparam int MIN_SIZE     = 6;
  localparam int SYNTH_BYTES  = 6;
  localparam int CMD_BYTES    = 8;
  localparam int HDR_BYTES    = 22;
  localparam int HDR_LEN_OFS  = 4;
  localparam int HDR_ENC_OFS  = 20;
  localparam logic [14:0] CMD_SOUND  = 15'd80;
  localparam logic [14:0] CMD_BUFFER = 15'd81;
  localparam logic [16:0] COUNT_MAX  = 17'h1FFFF;
  localparam logic [7:0]  SAMPLE_BIAS = 8'h80;

  // Report status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_FORMAT   = 2'd2;
  localparam logic [1:0] ST_NO_SOUND = 2'd3;

  // Fetch start address selects
  typedef logic [2:0] addr_sel_t;
  localparam addr_sel_t A_ZERO  = 3'd0;
  localparam addr_sel_t A_TWO   = 3'd1;
  localparam addr_sel_t A_OFF   = 3'd2;
  localparam addr_sel_t A_HDR4  = 3'd3;
  localparam addr_sel_t A_HDR20 = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic       wr;
    logic       rd_fetch;
    logic       rd_sample;
    logic       addr_load;
    addr_sel_t  addr_sel;
    logic       shift;
    logic       off_syn;
    logic       off_add2;
    logic       off_add8;
    logic       cnt_load;
    logic       cnt_dec;
    logic       hdr_load;
    logic       len_load;
    logic       report;
    logic [1:0] rep_status;
    logic       out_sample;
  } sse_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic size_short;
    logic fmt_ok;
    logic syn_neg;
    logic off_fit2;
    logic cnt_zero;
    logic off_fit8;
    logic kind_ok;
    logic hdr_fit;
    logic enc_zero;
    logic len_nz;
  } sse_stat_t;

endpackage

### design/sse_dp.sv
`timescale 1ns / 1ps

module sse_dp import sse_pkg::*; #(
  parameter int RESOURCE_BYTES = RES_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  sse_cmd_t           cmd,
  output sse_stat_t          stat,
  input  logic [7:0]         data_byte,
  input  logic [15:0]        sample_index,
  output logic               result_kind,
  output logic [1:0]         status,
  output logic [15:0]        rate_hz,
  output logic [16:0]        sample_count,
  output logic signed [7:0]  sample_value
);

  localparam int AW = $clog2(RESOURCE_BYTES);
  localparam int LW = $clog2(RESOURCE_BYTES + 1);

  logic [7:0]       mem [RESOURCE_BYTES];
  logic [7:0]       rdata;
  logic [LW-1:0]    load_len;
  logic [AW-1:0]    addr;
  logic [AW-1:0]    rd_addr;
  logic [63:0]      sr;
  logic [OFS_W-1:0] off;
  logic [14:0]      cnt;
  logic [31:0]      hdr;
  logic [LW-1:0]    len;
  logic [15:0]      rate_tmp;
  logic [AW-1:0]    base;
  logic [16:0]      count;
  logic [15:0]      rate;
  logic             hit;

  logic [OFS_W-1:0] size_w;
  logic [OFS_W-1:0] hdr_w;
  logic [OFS_W-1:0] samp_w;
  logic [OFS_W-1:0] len_raw;
  logic [OFS_W-1:0] len_clip;
  logic [OFS_W-1:0] len_w;
  logic [OFS_W-1:0] start_w;
  logic [OFS_W-1:0] samp_addr_w;
  logic [16:0]      count_sat;

  assign size_w      = OFS_W'(load_len);
  assign hdr_w       = OFS_W'(hdr);
  assign samp_w      = hdr_w + OFS_W'(HDR_BYTES);
  assign len_raw     = OFS_W'(sr[63:32]);
  assign len_clip    = (samp_w + len_raw > size_w) ? (size_w - samp_w) : len_raw;
  assign len_w       = OFS_W'(len);
  assign count_sat   = (len_w > OFS_W'(COUNT_MAX)) ? COUNT_MAX : len_w[16:0];
  assign samp_addr_w = OFS_W'(base) + OFS_W'(sample_index);

  // Status toward the controller
  assign stat.size_short = size_w < OFS_W'(MIN_SIZE);
  assign stat.fmt_ok     = sr[15:0] == 16'd1;
  assign stat.syn_neg    = sr[15];
  assign stat.off_fit2   = off + OFS_W'(2) <= size_w;
  assign stat.cnt_zero   = cnt == '0;
  assign stat.off_fit8   = off + OFS_W'(CMD_BYTES) <= size_w;
  assign stat.kind_ok    = sr[62:48] == CMD_SOUND || sr[62:48] == CMD_BUFFER;
  assign stat.hdr_fit    = samp_w <= size_w;
  assign stat.enc_zero   = sr[7:0] == 8'd0;
  assign stat.len_nz     = len != '0;

  // Select fetch start address
  always_comb begin
    case (cmd.addr_sel)
      A_ZERO:  start_w = '0;
      A_TWO:   start_w = OFS_W'(2);
      A_OFF:   start_w = off;
      A_HDR4:  start_w = hdr_w + OFS_W'(HDR_LEN_OFS);
      A_HDR20: start_w = hdr_w + OFS_W'(HDR_ENC_OFS);
      default: start_w = '0;
    endcase
  end

  assign rd_addr = cmd.rd_sample ? samp_addr_w[AW-1:0] : addr;

  // Store resource bytes
  always_ff @(posedge clk) begin
    if (cmd.wr && load_len < LW'(RESOURCE_BYTES)) begin
      mem[load_len[AW-1:0]] <= data_byte;
    end
  end

  // Read one byte a cycle while a fetch or sample read is commanded
  always_ff @(posedge clk) begin
    if (cmd.rd_fetch || cmd.rd_sample) begin
      rdata <= mem[rd_addr];
    end
  end

  // Count loaded bytes, restart after a parse
  always_ff @(posedge clk) begin
    if (rst) begin
      load_len <= '0;
    end else if (cmd.report) begin
      load_len <= '0;
    end else if (cmd.wr && load_len < LW'(RESOURCE_BYTES)) begin
      load_len <= load_len + LW'(1);
    end
  end

  // Parse working registers
  always_ff @(posedge clk) begin
    if (cmd.addr_load) begin
      addr <= start_w[AW-1:0];
    end else if (cmd.rd_fetch) begin
      addr <= addr + AW'(1);
    end
    if (cmd.shift) begin
      sr <= {sr[55:0], rdata};
    end
    if (cmd.off_syn) begin
      off <= OFS_W'(4) + OFS_W'({sr[14:0], 2'b00}) + OFS_W'({sr[14:0], 1'b0});
    end else if (cmd.off_add2) begin
      off <= off + OFS_W'(2);
    end else if (cmd.off_add8) begin
      off <= off + OFS_W'(CMD_BYTES);
    end
    if (cmd.cnt_load) begin
      cnt <= sr[15] ? '0 : sr[14:0];
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - 15'd1;
    end
    if (cmd.hdr_load) begin
      hdr <= sr[31:0];
    end
    if (cmd.len_load) begin
      len      <= len_clip[LW-1:0];
      rate_tmp <= sr[31:16];
    end
    if (cmd.rd_sample) begin
      hit <= {1'b0, sample_index} < count;
    end
  end

  // Commit or clear parse results
  always_ff @(posedge clk) begin
    if (rst) begin
      base  <= '0;
      count <= '0;
      rate  <= '0;
    end else if (cmd.report) begin
      if (cmd.rep_status == ST_OK) begin
        base  <= samp_w[AW-1:0];
        count <= count_sat;
        rate  <= rate_tmp;
      end else begin
        base  <= '0;
        count <= '0;
        rate  <= '0;
      end
    end
  end

  // Load result item
  always_ff @(posedge clk) begin
    if (cmd.report) begin
      result_kind  <= 1'b0;
      status       <= cmd.rep_status;
      rate_hz      <= (cmd.rep_status == ST_OK) ? rate_tmp : 16'd0;
      sample_count <= (cmd.rep_status == ST_OK) ? count_sat : 17'd0;
      sample_value <= '0;
    end else if (cmd.out_sample) begin
      result_kind  <= 1'b1;
      status       <= ST_OK;
      rate_hz      <= rate;
      sample_count <= count;
      sample_value <= hit ? (rdata ^ SAMPLE_BIAS) : 8'd0;
    end
  end

endmodule

### design/sse_ctrl.sv
`timescale 1ns / 1ps

module sse_ctrl import sse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      opcode,
  input  logic      last_byte,
  input  sse_stat_t stat,
  output sse_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_READ  = 4'd1;
  localparam logic [3:0] S_CHK   = 4'd2;
  localparam logic [3:0] S_FMT   = 4'd3;
  localparam logic [3:0] S_SYN   = 4'd4;
  localparam logic [3:0] S_SYN2  = 4'd5;
  localparam logic [3:0] S_NCMD  = 4'd6;
  localparam logic [3:0] S_LOOP  = 4'd7;
  localparam logic [3:0] S_KIND  = 4'd8;
  localparam logic [3:0] S_KIND2 = 4'd9;
  localparam logic [3:0] S_HDR   = 4'd10;
  localparam logic [3:0] S_ENC   = 4'd11;
  localparam logic [3:0] S_FETCH = 4'd12;
  localparam logic [3:0] S_DRAIN = 4'd13;

  localparam logic OP_LOAD = 1'b0;

  logic [3:0] state, state_next;
  logic [3:0] ret, ret_next;
  logic [3:0] fcnt, fcnt_next;
  logic       pend;

  logic       fetch;
  addr_sel_t  f_sel;
  logic [3:0] f_len;
  logic [3:0] f_ret;
  logic       rep;
  logic [1:0] rep_st;

  assign busy = state != S_IDLE;

  // Sequence the parse and reads
  always_comb begin
    cmd        = '0;
    state_next = state;
    ret_next   = ret;
    fcnt_next  = fcnt;
    fetch      = 1'b0;
    f_sel      = A_ZERO;
    f_len      = 4'd0;
    f_ret      = ret;
    rep        = 1'b0;
    rep_st     = ST_OK;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (opcode == OP_LOAD) begin
            cmd.wr = 1'b1;
            if (last_byte) begin
              state_next = S_CHK;
            end
          end else begin
            cmd.rd_sample = 1'b1;
            state_next    = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.out_sample = 1'b1;
        state_next     = S_IDLE;
      end
      S_CHK: begin
        if (stat.size_short) begin
          rep    = 1'b1;
          rep_st = ST_SHORT;
        end else begin
          fetch = 1'b1;
          f_sel = A_ZERO;
          f_len = 4'd2;
          f_ret = S_FMT;
        end
      end
      S_FMT: begin
        if (!stat.fmt_ok) begin
          rep    = 1'b1;
          rep_st = ST_FORMAT;
        end else begin
          fetch = 1'b1;
          f_sel = A_TWO;
          f_len = 4'd2;
          f_ret = S_SYN;
        end
      end
      S_SYN: begin
        if (stat.syn_neg) begin
          rep    = 1'b1;
          rep_st = ST_FORMAT;
        end else begin
          cmd.off_syn = 1'b1;
          state_next  = S_SYN2;
        end
      end
      S_SYN2: begin
        if (!stat.off_fit2) begin
          rep    = 1'b1;
          rep_st = ST_SHORT;
        end else begin
          fetch = 1'b1;
          f_sel = A_OFF;
          f_len = 4'd2;
          f_ret = S_NCMD;
        end
      end
      S_NCMD: begin
        cmd.cnt_load = 1'b1;
        cmd.off_add2 = 1'b1;
        state_next   = S_LOOP;
      end
      S_LOOP: begin
        if (stat.cnt_zero || !stat.off_fit8) begin
          rep    = 1'b1;
          rep_st = ST_NO_SOUND;
        end else begin
          fetch = 1'b1;
          f_sel = A_OFF;
          f_len = 4'd8;
          f_ret = S_KIND;
        end
      end
      S_KIND: begin
        cmd.hdr_load = 1'b1;
        cmd.off_add8 = 1'b1;
        cmd.cnt_dec  = 1'b1;
        state_next   = S_KIND2;
      end
      S_KIND2: begin
        if (stat.kind_ok && stat.hdr_fit) begin
          fetch = 1'b1;
          f_sel = A_HDR4;
          f_len = 4'd8;
          f_ret = S_HDR;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_HDR: begin
        cmd.len_load = 1'b1;
        fetch        = 1'b1;
        f_sel        = A_HDR20;
        f_len        = 4'd1;
        f_ret        = S_ENC;
      end
      S_ENC: begin
        if (stat.enc_zero && stat.len_nz) begin
          rep    = 1'b1;
          rep_st = ST_OK;
        end else begin
          state_next = S_LOOP;
        end
      end
      S_FETCH: begin
        cmd.rd_fetch = 1'b1;
        fcnt_next    = fcnt - 4'd1;
        if (fcnt == 4'd1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = ret;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // Launch a byte fetch and return afterward
    if (fetch) begin
      cmd.addr_load = 1'b1;
      cmd.addr_sel  = f_sel;
      fcnt_next     = f_len;
      ret_next      = f_ret;
      state_next    = S_FETCH;
    end
    // Emit the parse report
    if (rep) begin
      cmd.report     = 1'b1;
      cmd.rep_status = rep_st;
      state_next     = S_IDLE;
    end
    cmd.shift = pend;
  end

  // Hold state, fetch count and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      fcnt  <= '0;
      pend  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      fcnt  <= fcnt_next;
      pend  <= cmd.rd_fetch;
      done  <= cmd.report || cmd.out_sample;
    end
  end

endmodule

### design/snd_resource_sample_extractor.sv
`timescale 1ns / 1ps

// Sound resource sample extractor. Load bytes with opcode 0, one per cycle with
// busy staying low; the byte marked last_byte starts a parse that holds busy
// high while a walker reads the store one byte a cycle through its single read
// port: fixed checks first, then each command walked, then a candidate header.
// A read (opcode 1) fetches its sample byte, then loads the result. Every
// result appears for exactly one cycle with done high and is not held: the
// receiver must take it in that cycle. After reset the block is ready at once.

module snd_resource_sample_extractor import sse_pkg::*; #(
  parameter int RESOURCE_BYTES = RES_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              opcode,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  input  logic [15:0]       sample_index,
  output logic              done,
  output logic              result_kind,
  output logic [1:0]        status,
  output logic [15:0]       rate_hz,
  output logic [16:0]       sample_count,
  output logic signed [7:0] sample_value
);

  sse_cmd_t  cmd;
  sse_stat_t stat;

  // Sequencer
  sse_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .last_byte (last_byte),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .done      (done)
  );

  // Store, offset arithmetic and result registers
  sse_dp #(
    .RESOURCE_BYTES (RESOURCE_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .data_byte    (data_byte),
    .sample_index (sample_index),
    .result_kind  (result_kind),
    .status       (status),
    .rate_hz      (rate_hz),
    .sample_count (sample_count),
    .sample_value (sample_value)
  );

endmodule

### bench/snd_resource_sample_extractor_test.sv
`timescale 1ns / 1ps

module snd_resource_sample_extractor_test;
  import sse_pkg::*;

  localparam int STORE_BYTES = RES_BYTES_DEF;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [15:0] rate;
    logic [16:0] count;
    logic [7:0]  value;
  } extract_result_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              start;
  logic              busy;
  logic              opcode;
  logic [7:0]        data_byte;
  logic              last_byte;
  logic [15:0]       sample_index;
  logic              done;
  logic              result_kind;
  logic [1:0]        status;
  logic [15:0]       rate_hz;
  logic [16:0]       sample_count;
  logic signed [7:0] sample_value;

  // Predicted copy of the block's state
  logic [7:0]  res_mem [0:STORE_BYTES-1];
  logic [16:0] load_len;
  logic [15:0] samp_base;
  logic [16:0] samp_count;
  logic [15:0] samp_rate;

  extract_result_t pending_results [$];
  extract_result_t oldest;
  logic [7:0]      res_bytes [$];

  bit burst;
  int n_items;
  int n_reports;
  int n_reads;
  int n_errors;

  snd_resource_sample_extractor #(
    .RESOURCE_BYTES(STORE_BYTES)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .data_byte    (data_byte),
    .last_byte    (last_byte),
    .sample_index (sample_index),
    .done         (done),
    .result_kind  (result_kind),
    .status       (status),
    .rate_hz      (rate_hz),
    .sample_count (sample_count),
    .sample_value (sample_value)
  );

  always #5 clk = ~clk;

  // Big-endian reads of the predicted store; outside the store reads as zero
  function automatic logic [7:0] rd8(input longint a);
    if (a < 0 || a >= STORE_BYTES) return 8'h00;
    return res_mem[a[15:0]];
  endfunction

  function automatic logic [15:0] rd16(input longint a);
    return {rd8(a), rd8(a + 1)};
  endfunction

  function automatic logic [31:0] rd32(input longint a);
    return {rd16(a), rd16(a + 2)};
  endfunction

  // Parse the loaded resource and update base, count and rate
  function automatic logic [1:0] parse_stored_resource();
    longint      size;
    longint      off;
    longint      hdr;
    longint      len;
    longint      samp;
    logic [15:0] w;
    logic [31:0] rate_fix;
    int          synths;
    int          cmds;
    samp_base  = '0;
    samp_count = '0;
    samp_rate  = '0;
    size = load_len;
    if (size < MIN_SIZE) return ST_SHORT;
    if (rd16(0) != 16'd1) return ST_FORMAT;
    w = rd16(2);
    synths = int'($signed(w));
    if (synths < 0) return ST_FORMAT;
    off = 4 + longint'(synths) * SYNTH_BYTES;
    if (off + 2 > size) return ST_SHORT;
    w = rd16(off);
    cmds = int'($signed(w));
    off += 2;
    for (int i = 0; i < cmds; i++) begin
      if (off + CMD_BYTES > size) break;
      w = rd16(off);
      hdr = rd32(off + 4);
      off += CMD_BYTES;
      if (w[14:0] != CMD_BUFFER && w[14:0] != CMD_SOUND) continue;
      if (hdr + HDR_BYTES > size) continue;
      len = rd32(hdr + HDR_LEN_OFS);
      if (rd8(hdr + HDR_ENC_OFS) != 8'h00) continue;
      samp = hdr + HDR_BYTES;
      if (samp + len > size) len = size - samp;
      if (len <= 0) continue;
      samp_base  = samp[15:0];
      samp_count = (len > longint'(COUNT_MAX)) ? COUNT_MAX : len[16:0];
      rate_fix   = rd32(hdr + 8);
      samp_rate  = rate_fix[31:16];
      return ST_OK;
    end
    return ST_NO_SOUND;
  endfunction

  // Work out the result of one accepted item and queue it
  task automatic predict_extraction(input logic op, input logic [7:0] data,
                                    input logic last, input logic [15:0] idx);
    extract_result_t r;
    logic [15:0]     addr;
    r = '0;
    if (!op) begin
      if (load_len < STORE_BYTES) begin
        res_mem[load_len[15:0]] = data;
        load_len++;
      end
      if (!last) return;
      r.status = parse_stored_resource();
      load_len = '0;
    end else begin
      r.kind = 1'b1;
      if ({1'b0, idx} < samp_count) begin
        addr    = samp_base + idx;
        r.value = res_mem[addr] - SAMPLE_BIAS;
      end
    end
    r.rate  = samp_rate;
    r.count = samp_count;
    pending_results.push_back(r);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 60);
  endfunction

  // Drive one item at the falling edge and hold it until accepted
  task automatic send_item(input logic op, input logic [7:0] data,
                           input logic last, input logic [15:0] idx);
    int gap;
    gap = burst ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    opcode       = op;
    data_byte    = data;
    last_byte    = last;
    sample_index = idx;
    start        = 1'b1;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    n_items++;
    predict_extraction(op, data, last, idx);
  endtask

  task automatic read_sample(input logic [15:0] idx);
    send_item(1'b1, 8'($urandom), 1'($urandom), idx);
  endtask

  // Send the built resource; mark the final byte only when asked
  task automatic load_resource(input bit mark_last);
    for (int i = 0; i < res_bytes.size(); i++)
      send_item(1'b0, res_bytes[i], mark_last && (i == res_bytes.size() - 1),
                16'($urandom));
  endtask

  task automatic push16(input logic [15:0] w);
    res_bytes.push_back(w[15:8]);
    res_bytes.push_back(w[7:0]);
  endtask

  task automatic push32(input logic [31:0] w);
    push16(w[31:16]);
    push16(w[15:0]);
  endtask

  function automatic logic [15:0] good_kind();
    return {1'($urandom), ($urandom_range(0, 1) != 0) ? CMD_BUFFER : CMD_SOUND};
  endfunction

  // Build a resource: synths, nbad skipped commands, one sound command,
  // then its header and nsamp sample bytes
  task automatic build_sound(input int nsyn, input int nbad, input int ncmd_adj,
                             input logic [15:0] kind_word, input logic [31:0] len_word,
                             input int nsamp, input logic [7:0] enc,
                             input logic [31:0] rate_word);
    int          hdr;
    logic [15:0] w;
    res_bytes.delete();
    push16(16'd1);
    push16(16'(nsyn));
    repeat (nsyn * SYNTH_BYTES) res_bytes.push_back(8'($urandom));
    push16(16'(nbad + 1 + ncmd_adj));
    repeat (nbad) begin
      if ($urandom_range(0, 3) == 0) begin
        // playable kind, header far outside the resource
        push16(good_kind());
        push16(16'($urandom));
        push32({1'b1, 31'($urandom)});
      end else begin
        w = 16'($urandom);
        while (w[14:0] == CMD_SOUND || w[14:0] == CMD_BUFFER) w = 16'($urandom);
        push16(w);
        push16(16'($urandom));
        push32($urandom);
      end
    end
    hdr = 4 + nsyn * SYNTH_BYTES + 2 + CMD_BYTES * (nbad + 1);
    push16(kind_word);
    push16(16'($urandom));
    push32(32'(hdr));
    push32($urandom);
    push32(len_word);
    push32(rate_word);
    push32($urandom);
    push32($urandom);
    res_bytes.push_back(enc);
    res_bytes.push_back(8'($urandom));
    repeat (nsamp) res_bytes.push_back(8'($urandom));
  endtask

  task automatic build_random_sound();
    int          nsamp;
    int          r;
    int          adj;
    logic [31:0] len_word;
    logic [7:0]  enc;
    nsamp = $urandom_range(1, 24);
    r = $urandom_range(0, 9);
    if (r < 6) len_word = 32'(nsamp);
    else if (r < 8) len_word = 32'($urandom_range(1, nsamp));
    else if (r < 9) len_word = $urandom;
    else len_word = '0;
    enc = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
    adj = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 2)) - 1 : 0;
    build_sound($urandom_range(0, 2), $urandom_range(0, 3), adj, good_kind(),
                len_word, nsamp, enc, $urandom);
  endtask

  // Compare one result field
  task automatic check_field(input string name, input logic [31:0] expv,
                             input logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expv, actv);
      n_errors++;
    end
  endtask

  // Check each strobed result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: kind %0d status %0d", result_kind, status);
        n_errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (oldest.kind) n_reads++;
        else n_reports++;
        check_field("result_kind", 32'(oldest.kind), 32'(result_kind));
        check_field("status", 32'(oldest.status), 32'(status));
        check_field("rate_hz", 32'(oldest.rate), 32'(rate_hz));
        check_field("sample_count", 32'(oldest.count), 32'(sample_count));
        check_field("sample_value", 32'(oldest.value), 32'($unsigned(sample_value)));
      end
    end
  end

  // Reads right after reset see no sound
  task automatic test_reset_reads();
    read_sample(16'd0);
    read_sample(16'hFFFF);
  endtask

  task automatic test_short_resources();
    res_bytes.delete();
    res_bytes.push_back(8'h00);
    load_resource(1'b1);
    res_bytes = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h00};
    load_resource(1'b1);
    // one synth leaves no room for the command count
    res_bytes = '{8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h00};
    load_resource(1'b1);
    read_sample(16'd0);
  endtask

  task automatic test_bad_format();
    res_bytes = '{8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'h01};
    load_resource(1'b1);
    res_bytes = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01};
    load_resource(1'b1);
    // negative synth count
    res_bytes = '{8'h00, 8'h01, 8'h80, 8'h00, 8'h00, 8'h01};
    load_resource(1'b1);
  endtask

  task automatic test_no_sound();
    res_bytes = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00};
    load_resource(1'b1);
    res_bytes = '{8'h00, 8'h01, 8'h00, 8'h00, 8'h80, 8'h00};
    load_resource(1'b1);
    // only skipped commands are walked
    build_sound(1, 2, -1, {1'b0, CMD_SOUND}, 32'd4, 4, 8'h00, $urandom);
    load_resource(1'b1);
    // nonzero encode
    build_sound(0, 0, 0, {1'b0, CMD_SOUND}, 32'd8, 8, 8'h01, $urandom);
    load_resource(1'b1);
    // zero length
    build_sound(0, 1, 0, {1'b0, CMD_BUFFER}, 32'd0, 4, 8'h00, $urandom);
    load_resource(1'b1);
    // header offset far past the end
    build_sound(0, 0, 0, {1'b0, CMD_SOUND}, 32'd4, 4, 8'h00, $urandom);
    for (int i = 10; i < 14; i++) res_bytes[i] = 8'hFF;
    load_resource(1'b1);
    // command runs past the end
    build_sound(0, 0, 0, {1'b0, CMD_SOUND}, 32'd4, 4, 8'h00, $urandom);
    while (res_bytes.size() > 10) void'(res_bytes.pop_back());
    load_resource(1'b1);
    // header ends the resource, clipped length is zero
    build_sound(0, 0, 0, {1'b0, CMD_BUFFER}, 32'd16, 0, 8'h00, $urandom);
    load_resource(1'b1);
    read_sample(16'd0);
  endtask

  task automatic test_good_sounds();
    int n;
    build_sound(2, 1, 0, {1'b0, CMD_SOUND}, 32'd8, 8, 8'h00, 32'h5622_0000);
    n = res_bytes.size();
    res_bytes[n - 3] = 8'h00;
    res_bytes[n - 2] = 8'h80;
    res_bytes[n - 1] = 8'hFF;
    load_resource(1'b1);
    for (int i = 0; i <= 8; i++) read_sample(16'(i));
    read_sample(16'hFFFF);
    // top flag set, huge length clipped, top rate
    build_sound(0, 0, 0, {1'b1, CMD_BUFFER}, 32'hFFFF_FFFF, 5, 8'h00, 32'hFFFF_FFFF);
    load_resource(1'b1);
    for (int i = 0; i <= 5; i++) read_sample(16'(i));
    // command count far larger than the commands present
    build_sound(0, 0, 32766, {1'b0, CMD_SOUND}, 32'd3, 3, 8'h00, $urandom);
    load_resource(1'b1);
    // length shorter than the data
    build_sound(1, 3, 0, good_kind(), 32'd3, 10, 8'h00, $urandom);
    load_resource(1'b1);
    for (int i = 0; i <= 3; i++) read_sample(16'(i));
  endtask

  // New loads overwrite samples that are still being read
  task automatic test_overwrite();
    build_sound(0, 0, 0, {1'b0, CMD_SOUND}, 32'd12, 12, 8'h00, $urandom);
    load_resource(1'b1);
    read_sample(16'd3);
    build_sound(0, 0, 0, {1'b0, CMD_BUFFER}, 32'd6, 6, 8'h00, $urandom);
    load_resource(1'b0);
    for (int i = 0; i < 12; i++) read_sample(16'(i));
    send_item(1'b0, 8'($urandom), 1'b1, 16'($urandom));
    read_sample(16'd0);
  endtask

  // Fill the store past its end; the extra bytes drop and the parse still runs
  task automatic test_full_store();
    build_sound(0, 0, 0, {1'b0, CMD_BUFFER}, 32'hFFFF_FFFF, STORE_BYTES + 4 - 36,
                8'h00, $urandom);
    burst = 1'b1;
    load_resource(1'b1);
    burst = 1'b0;
    read_sample(16'd0);
    read_sample(16'd65499);
    read_sample(16'd65500);
    read_sample(16'hFFFF);
    repeat (4) read_sample(16'($urandom));
  endtask

  task automatic test_random_resources();
    int target;
    int choice;
    target = n_items + 550;
    while (n_items < target) begin
      burst = ($urandom_range(0, 5) == 0);
      choice = $urandom_range(0, 99);
      if (choice < 85) begin
        build_random_sound();
        if (choice >= 70) begin
          // break the sequence: truncate it or scramble a few bytes
          if ($urandom_range(0, 1) != 0)
            repeat ($urandom_range(1, res_bytes.size() - 1)) void'(res_bytes.pop_back());
          else
            repeat ($urandom_range(1, 3))
              res_bytes[$urandom_range(0, res_bytes.size() - 1)] = 8'($urandom);
        end
      end else begin
        res_bytes.delete();
        repeat ($urandom_range(1, 12)) res_bytes.push_back(8'($urandom));
        if (res_bytes.size() >= 2 && $urandom_range(0, 1) != 0) begin
          res_bytes[0] = 8'h00;
          res_bytes[1] = 8'h01;
        end
      end
      load_resource(1'b1);
      repeat ($urandom_range(1, 8)) begin
        if ($urandom_range(0, 9) < 7) read_sample(16'($urandom_range(0, 31)));
        else read_sample(16'($urandom));
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = 1'b0;
    data_byte    = '0;
    last_byte    = 1'b0;
    sample_index = '0;
    load_len     = '0;
    samp_base    = '0;
    samp_count   = '0;
    samp_rate    = '0;
    burst        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_reads();
    test_short_resources();
    test_bad_format();
    test_no_sound();
    test_good_sounds();
    test_overwrite();
    test_full_store();
    test_random_resources();

    // Drain, then watch for stray strobes
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d items: %0d parse reports and %0d sample reads checked",
             n_items, n_reports, n_reads);
    if (n_errors == 0) $display("snd_resource_sample_extractor_test: clean");
    else $display("snd_resource_sample_extractor_test: errors");
    $finish;
  end

  // Hard stop on a hung run
  initial begin
    #(10_000_000);
    $display("timeout with %0d results pending", pending_results.size());
    $display("snd_resource_sample_extractor_test: errors");
    $finish;
  end

endmodule

### filelist.f
design/sse_pkg.sv
design/sse_dp.sv
design/sse_ctrl.sv
design/snd_resource_sample_extractor.sv
bench/snd_resource_sample_extractor_test.sv
